>>> rtl/rpsd_pkg.sv
// Shared types, status codes and header table of the run-length page decoder.
// No dependencies.
package rpsd_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned CountW  = 4;
  localparam int unsigned BwW     = 15;
  localparam int unsigned StatusW = 3;
  localparam logic [BwW-1:0] SmallPage = 15'd8192;

  localparam logic [StatusW-1:0] ST_BUSY    = 3'd0;
  localparam logic [StatusW-1:0] ST_OK      = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_HDR = 3'd2;
  localparam logic [StatusW-1:0] ST_OVF     = 3'd3;
  localparam logic [StatusW-1:0] ST_TRUNC   = 3'd4;
  localparam logic [StatusW-1:0] ST_TRAIL   = 3'd5;

  typedef struct packed {
    logic               hdr_inc;
    logic               hdr_clr;
    logic               pend_load;
    logic               lit_wr;
    logic               run_start;
    logic               chunk_next;
    logic               zero_out;
    logic               clear;
    logic [StatusW-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic hdr_done;
    logic tok_ovf;
    logic tok_run;
    logic pend_one;
    logic lit_full;
    logic run_full;
    logic run_more;
    logic left_more;
    logic slot_free;
  } sts_t;

  function automatic logic [7:0] hdr_byte(input logic mode, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd0:    b = mode ? 8'h48 : 8'h44;
      3'd1:    b = mode ? 8'h47 : 8'h48;
      3'd2:    b = 8'h52;
      3'd3:    b = 8'h52;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h00;
      3'd6:    b = 8'h00;
      3'd7:    b = mode ? 8'h20 : 8'h40;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/rpsd_ctrl.sv
// Decode phase state machine and result sequencing of the page decoder.
// Depends on rpsd_pkg.
module rpsd_ctrl import rpsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_TOKEN     = 3'd1;
  localparam logic [2:0] PH_LITERAL   = 3'd2;
  localparam logic [2:0] PH_RUNVAL    = 3'd3;
  localparam logic [2:0] PH_FULL      = 3'd4;
  localparam logic [2:0] PH_ERR_HDR   = 3'd5;
  localparam logic [2:0] PH_ERR_OVF   = 3'd6;
  localparam logic [2:0] PH_ERR_TRAIL = 3'd7;

  logic [2:0] phase_q, phase_d;
  logic       emit_q, emit_d;
  logic       accept;
  logic [2:0] nph;

  assign in_stall_o = emit_q || !sts_i.slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    nph     = phase_q;
    phase_d = phase_q;
    emit_d  = emit_q;
    if (emit_q && sts_i.slot_free) begin
      cmd_o.chunk_next = 1'b1;
      emit_d           = sts_i.left_more;
    end
    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (!sts_i.hdr_match) begin
            nph = PH_ERR_HDR;
          end else if (sts_i.hdr_done) begin
            nph           = PH_TOKEN;
            cmd_o.hdr_clr = 1'b1;
          end else begin
            cmd_o.hdr_inc = 1'b1;
          end
        end
        PH_TOKEN: begin
          if (sts_i.tok_ovf) begin
            nph = PH_ERR_OVF;
          end else begin
            cmd_o.pend_load = 1'b1;
            nph = sts_i.tok_run ? PH_RUNVAL : PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          cmd_o.lit_wr = 1'b1;
          if (sts_i.pend_one) begin
            nph = sts_i.lit_full ? PH_FULL : PH_TOKEN;
          end
        end
        PH_RUNVAL: begin
          cmd_o.run_start = 1'b1;
          emit_d          = sts_i.run_more;
          nph             = sts_i.run_full ? PH_FULL : PH_TOKEN;
        end
        PH_FULL: begin
          nph = PH_ERR_TRAIL;
        end
        default: begin
          nph = phase_q;
        end
      endcase
      cmd_o.zero_out = !cmd_o.lit_wr && !cmd_o.run_start;
      if (nph == PH_ERR_HDR) begin
        cmd_o.status = ST_BAD_HDR;
      end else if (nph == PH_ERR_OVF) begin
        cmd_o.status = ST_OVF;
      end else if (nph == PH_ERR_TRAIL) begin
        cmd_o.status = ST_TRAIL;
      end else if (!in_last_i) begin
        cmd_o.status = ST_BUSY;
      end else if (nph == PH_FULL) begin
        cmd_o.status = ST_OK;
      end else if (nph == PH_HEADER) begin
        cmd_o.status = ST_BAD_HDR;
      end else begin
        cmd_o.status = ST_TRUNC;
      end
      phase_d = nph;
      if (in_last_i) begin
        phase_d     = PH_HEADER;
        cmd_o.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      emit_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      emit_q  <= emit_d;
    end
  end

endmodule

>>> rtl/rpsd_datapath.sv
// Counters, page arithmetic, run packing and output register of the page decoder.
// Depends on rpsd_pkg.
module rpsd_datapath import rpsd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8,
  parameter int unsigned MAX_PAGE_BYTES   = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [7:0]         in_byte_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataW-1:0]   out_data_o,
  output logic [CountW-1:0]  out_count_o,
  output logic [StatusW-1:0] status_o,
  output logic               group_last_o
);

  localparam logic [7:0]     Bpr     = 8'(BYTES_PER_RESULT);
  localparam logic [BwW-1:0] BigPage = BwW'(MAX_PAGE_BYTES);

  logic               mode_q;
  logic [2:0]         hdr_idx_q;
  logic [BwW-1:0]     bw_q, bw_d;
  logic [7:0]         pend_q, pend_d;
  logic [7:0]         left_q;
  logic [7:0]         run_byte_q;
  logic [StatusW-1:0] run_st_q;
  logic               out_valid_q;
  logic [DataW-1:0]   out_data_q;
  logic [CountW-1:0]  out_count_q;
  logic [StatusW-1:0] out_st_q;
  logic               out_last_q;

  logic [BwW-1:0]     page_size;
  logic [7:0]         tok_len;
  logic [BwW-1:0]     bw_lit, bw_run;
  logic [7:0]         sel_cnt, sel_byte;
  logic [CountW-1:0]  chunk_cnt;
  logic [DataW-1:0]   chunk_data;
  logic               chunk_load;

  assign page_size = mode_q ? SmallPage : BigPage;
  assign tok_len   = in_byte_i[7] ? ({1'b0, in_byte_i[6:0]} + 8'd3)
                                  : ({1'b0, in_byte_i[6:0]} + 8'd1);
  assign bw_lit    = bw_q + 15'd1;
  assign bw_run    = bw_q + BwW'(pend_q);

  assign sts_o.hdr_match = (in_byte_i == hdr_byte(mode_q, hdr_idx_q));
  assign sts_o.hdr_done  = (hdr_idx_q == 3'd7);
  assign sts_o.tok_ovf   = ((16'(bw_q) + 16'(tok_len)) > 16'(page_size));
  assign sts_o.tok_run   = in_byte_i[7];
  assign sts_o.pend_one  = (pend_q == 8'd1);
  assign sts_o.lit_full  = (bw_lit >= page_size);
  assign sts_o.run_full  = (bw_run >= page_size);
  assign sts_o.run_more  = (pend_q > Bpr);
  assign sts_o.left_more = (left_q > Bpr);
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  assign chunk_load = cmd_i.run_start || cmd_i.chunk_next;
  assign sel_cnt    = cmd_i.run_start ? pend_q : left_q;
  assign sel_byte   = cmd_i.run_start ? in_byte_i : run_byte_q;
  assign chunk_cnt  = (sel_cnt > Bpr) ? CountW'(BYTES_PER_RESULT) : sel_cnt[CountW-1:0];

  always_comb begin
    chunk_data = '0;
    for (int j = 0; j < BYTES_PER_RESULT; j++) begin
      if (CountW'(j) < chunk_cnt) begin
        chunk_data[8*j +: 8] = sel_byte;
      end
    end
  end

  always_comb begin
    bw_d   = bw_q;
    pend_d = pend_q;
    if (cmd_i.pend_load) begin
      pend_d = tok_len;
    end
    if (cmd_i.lit_wr) begin
      bw_d   = bw_lit;
      pend_d = pend_q - 8'd1;
    end
    if (cmd_i.run_start) begin
      bw_d   = bw_run;
      pend_d = 8'd0;
    end
    if (cmd_i.clear) begin
      bw_d   = '0;
      pend_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      hdr_idx_q   <= 3'd0;
      bw_q        <= '0;
      pend_q      <= 8'd0;
      left_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.hdr_clr || cmd_i.clear) begin
        hdr_idx_q <= 3'd0;
      end else if (cmd_i.hdr_inc) begin
        hdr_idx_q <= hdr_idx_q + 3'd1;
      end
      bw_q   <= bw_d;
      pend_q <= pend_d;
      if (chunk_load) begin
        left_q <= sel_cnt - 8'(chunk_cnt);
      end
      if (cmd_i.zero_out || cmd_i.lit_wr || chunk_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      run_byte_q <= in_byte_i;
      run_st_q   <= cmd_i.status;
    end
    if (cmd_i.zero_out) begin
      out_data_q  <= '0;
      out_count_q <= '0;
      out_st_q    <= cmd_i.status;
      out_last_q  <= 1'b1;
    end else if (cmd_i.lit_wr) begin
      out_data_q  <= DataW'(in_byte_i);
      out_count_q <= CountW'(1);
      out_st_q    <= cmd_i.status;
      out_last_q  <= 1'b1;
    end else if (chunk_load) begin
      out_data_q  <= chunk_data;
      out_count_q <= chunk_cnt;
      out_st_q    <= cmd_i.run_start ? cmd_i.status : run_st_q;
      out_last_q  <= !(sel_cnt > Bpr);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_count_o  = out_count_q;
  assign status_o     = out_st_q;
  assign group_last_o = out_last_q;

endmodule

>>> rtl/rle_page_stream_decoder.sv
// Top level of the run-length page decoder: controller plus datapath.
// Depends on rpsd_pkg, rpsd_ctrl and rpsd_datapath.
//
//   channel  handshake                    payload
//   input    in_valid_i / in_stall_o      in_byte_i, in_last_i
//   output   out_valid_o / out_stall_i    out_data_o, out_count_o, status_o, group_last_o
//   config   cfg_we_i                     cfg_wdata_i (page_mode)
//
// Header, token and literal bytes each give one item.
// A run byte gives ceil(run/BYTES_PER_RESULT) items, one per cycle while the output is not
// stalled, from the single output register; input is stalled until the last one is loaded.
// Output stall back-pressures the input through the output register.
// Reset (rst_ni low) returns to the header phase with page_mode 0.
module rle_page_stream_decoder import rpsd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8,
  parameter int unsigned MAX_PAGE_BYTES   = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataW-1:0]   out_data_o,
  output logic [CountW-1:0]  out_count_o,
  output logic [StatusW-1:0] status_o,
  output logic               group_last_o
);

  cmd_t cmd;
  sts_t sts;

  rpsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpsd_datapath #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT),
    .MAX_PAGE_BYTES   (MAX_PAGE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_byte_i    (in_byte_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .out_count_o  (out_count_o),
    .status_o     (status_o),
    .group_last_o (group_last_o)
  );

endmodule

>>> rtl/rpsd_checker.sv
// Port-level checks of the run-length page decoder, bound to the top level.
// Depends on rpsd_pkg and rle_page_stream_decoder.
module rpsd_checker import rpsd_pkg::*; #(
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [DataW-1:0]   out_data_o,
  input logic [CountW-1:0]  out_count_o,
  input logic [StatusW-1:0] status_o,
  input logic               group_last_o
);

  a_accept_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_count_o <= CountW'(BYTES_PER_RESULT))
    else $error("byte count above group size");

  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_count_o == '0 |-> out_data_o == '0 && group_last_o)
    else $error("empty item not zero or not last");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_TRAIL)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o)
      && $stable(out_count_o) && $stable(status_o) && $stable(group_last_o))
    else $error("stalled result changed");

endmodule

bind rle_page_stream_decoder rpsd_checker #(
  .BYTES_PER_RESULT (BYTES_PER_RESULT)
) u_rpsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_data_o   (out_data_o),
  .out_count_o  (out_count_o),
  .status_o     (status_o),
  .group_last_o (group_last_o)
);

>>> dv/tb_rle_page_stream_decoder.sv
// Testbench for rle_page_stream_decoder: a directed table, then random page files,
// each item checked field by field against an in-bench decoder.
// Depends on rpsd_pkg and the RTL of rle_page_stream_decoder.
module tb_rle_page_stream_decoder;
  import rpsd_pkg::*;

  localparam int HalfPeriod    = 6;
  localparam int CycleLimit    = 1_000_000;
  localparam int FullPageBytes = 16384;
  localparam int HalfPageBytes = 8192;
  localparam int BytesPerBeat  = 8;
  localparam int PhaseItems    = 10;
  localparam int TailCycles    = 40;
  localparam int MaxReports    = 10;
  localparam int DirRows       = 26;

  typedef enum logic [2:0] {
    PH_HDR, PH_TOK, PH_LIT, PH_RUN, PH_FULL, PH_EHDR, PH_EOVF, PH_ETRAIL
  } dec_phase_e;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_e;

  typedef struct packed {
    logic [DataW-1:0]   data;
    logic [CountW-1:0]  count;
    logic [StatusW-1:0] status;
    logic               glast;
  } beat_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [7:0]         b;
    logic               lst;
    logic               typed;
    logic [StatusW-1:0] st;
  } row_t;

  localparam logic [7:0] HdrTbl [2][8] = '{
    '{8'h44, 8'h48, 8'h52, 8'h52, 8'h01, 8'h00, 8'h00, 8'h40},
    '{8'h48, 8'h47, 8'h52, 8'h52, 8'h01, 8'h00, 8'h00, 8'h20}
  };

  // typed rows carry a single all-zero item with the given status
  localparam row_t DirTbl [DirRows] = '{
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, ST_BAD_HDR},
    '{ROW_BYTE, 8'h44, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h48, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h52, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h52, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h40, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h02, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'hff, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h5a, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'hff, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'ha5, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h05, 1'b1, 1'b1, ST_TRUNC},
    '{ROW_BYTE, 8'h44, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h48, 1'b0, 1'b0, ST_BUSY},
    '{ROW_MODE, 8'h01, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h52, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h52, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h20, 1'b0, 1'b0, ST_BUSY},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, ST_TRUNC}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [7:0]         in_byte_i   = 8'h00;
  logic               in_last_i   = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [DataW-1:0]   out_data_o;
  logic [CountW-1:0]  out_count_o;
  logic [StatusW-1:0] status_o;
  logic               group_last_o;

  // decoder copy kept by the bench
  dec_phase_e  dec_phase = PH_HDR;
  logic [2:0]  hdr_pos   = 3'd0;
  logic [14:0] out_total = 15'd0;
  logic [7:0]  pend_len  = 8'd0;
  logic        cfg_mode  = 1'b0;

  beat_t      step_beats[$];
  beat_t      want_q[$];
  logic [7:0] file_q[$];

  int snd_idle  = 0;
  int rcv_idle  = 0;
  int fail_cnt  = 0;
  int items_sent = 0;
  int cycles    = 0;

  rle_page_stream_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .out_count_o  (out_count_o),
    .status_o     (status_o),
    .group_last_o (group_last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < rcv_idle);

  function automatic int page_bytes();
    return cfg_mode ? HalfPageBytes : FullPageBytes;
  endfunction

  function automatic int room_left();
    return (int'(out_total) >= page_bytes()) ? 0 : page_bytes() - int'(out_total);
  endfunction

  // decodes one byte into step_beats and advances the bench state
  function automatic void decode_byte(input logic [7:0] b, input logic lst);
    int n;
    int left;
    int chunk;
    logic [DataW-1:0] d;
    logic [StatusW-1:0] st;
    step_beats.delete();
    case (dec_phase)
      PH_HDR: begin
        if (b != HdrTbl[cfg_mode][hdr_pos]) begin
          dec_phase = PH_EHDR;
        end else if (hdr_pos == 3'd7) begin
          hdr_pos = 3'd0;
          dec_phase = PH_TOK;
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
      end
      PH_TOK: begin
        n = b[7] ? int'(b[6:0]) + 3 : int'(b) + 1;
        if (n > room_left()) begin
          dec_phase = PH_EOVF;
        end else begin
          pend_len = 8'(n);
          dec_phase = b[7] ? PH_RUN : PH_LIT;
        end
      end
      PH_LIT: begin
        step_beats.insert(step_beats.size(),
                          '{data: DataW'(b), count: 4'd1, status: ST_BUSY, glast: 1'b0});
        out_total = out_total + 15'd1;
        pend_len = pend_len - 8'd1;
        if (pend_len == 8'd0) dec_phase = (int'(out_total) >= page_bytes()) ? PH_FULL : PH_TOK;
      end
      PH_RUN: begin
        left = int'(pend_len);
        while (left > 0) begin
          chunk = (left < BytesPerBeat) ? left : BytesPerBeat;
          d = '0;
          for (int j = 0; j < chunk; j++) d[8*j +: 8] = b;
          step_beats.insert(step_beats.size(),
                            '{data: d, count: 4'(chunk), status: ST_BUSY, glast: 1'b0});
          left -= chunk;
        end
        out_total = out_total + 15'(pend_len);
        pend_len = 8'd0;
        dec_phase = (int'(out_total) >= page_bytes()) ? PH_FULL : PH_TOK;
      end
      PH_FULL: dec_phase = PH_ETRAIL;
      default: ;
    endcase

    if (step_beats.size() == 0)
      step_beats.insert(0, '{data: '0, count: 4'd0, status: ST_BUSY, glast: 1'b0});

    if (dec_phase == PH_EHDR) st = ST_BAD_HDR;
    else if (dec_phase == PH_EOVF) st = ST_OVF;
    else if (dec_phase == PH_ETRAIL) st = ST_TRAIL;
    else if (!lst) st = ST_BUSY;
    else if (dec_phase == PH_FULL) st = ST_OK;
    else if (dec_phase == PH_HDR) st = ST_BAD_HDR;
    else st = ST_TRUNC;

    foreach (step_beats[i]) step_beats[i].status = st;
    step_beats[step_beats.size()-1].glast = 1'b1;

    if (lst) begin
      dec_phase = PH_HDR;
      hdr_pos   = 3'd0;
      out_total = 15'd0;
      pend_len  = 8'd0;
    end
  endfunction

  function automatic void note_fail(input string what, input beat_t want, input beat_t got);
    fail_cnt++;
    if (fail_cnt <= MaxReports)
      $display("%s: exp data=%h cnt=%0d st=%0d last=%b, got data=%h cnt=%0d st=%0d last=%b",
               what, want.data, want.count, want.status, want.glast,
               got.data, got.count, got.status, got.glast);
  endfunction

  always @(posedge clk_i) begin : check_out
    beat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{data: out_data_o, count: out_count_o, status: status_o, glast: group_last_o};
      if (want_q.size() == 0) begin
        note_fail("item with nothing expected", '0, got);
      end else begin
        if (got !== want_q[0]) note_fail("item mismatch", want_q[0], got);
        void'(want_q.pop_front());
      end
    end
  end

  task automatic feed_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input logic [StatusW-1:0] st);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_byte_i  <= b;
    in_last_i  <= lst;
    in_valid_i <= 1'b1;
    decode_byte(b, lst);
    if (typed)
      want_q.insert(want_q.size(), '{data: '0, count: 4'd0, status: st, glast: 1'b1});
    else foreach (step_beats[i]) want_q.insert(want_q.size(), step_beats[i]);
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (want_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    drain();
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_mode = m;
  endtask

  task automatic send_file(input logic end_last);
    foreach (file_q[i])
      feed_byte(file_q[i], end_last && (i == file_q.size() - 1), 1'b0, ST_BUSY);
    file_q.delete();
  endtask

  function automatic void add_header(input bit good);
    int bad_at;
    logic [7:0] b;
    bad_at = $urandom_range(7);
    for (int i = 0; i < 8; i++) begin
      b = HdrTbl[cfg_mode][i];
      if (!good && i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      file_q.insert(file_q.size(), b);
    end
  endfunction

  function automatic void add_noise(input int n);
    repeat (n) file_q.insert(file_q.size(), 8'($urandom_range(255)));
  endfunction

  function automatic void add_literal(input int len);
    file_q.insert(file_q.size(), 8'(len - 1));
    add_noise(len);
  endfunction

  function automatic void add_run(input int len);
    file_q.insert(file_q.size(), 8'h80 | 8'(len - 3));
    file_q.insert(file_q.size(), 8'($urandom_range(255)));
  endfunction

  // tokens that decode to exactly goal bytes
  function automatic void add_fill(input int goal);
    int rem;
    int len;
    rem = goal;
    while (rem > 0) begin
      if (rem < 3 || $urandom_range(99) < 2) begin
        len = $urandom_range(1, (rem < 8) ? rem : 8);
        add_literal(len);
      end else begin
        len = (rem <= 130) ? rem : $urandom_range(120, 130);
        add_run(len);
      end
      rem -= len;
    end
  endfunction

  function automatic void add_tokens(input int n);
    repeat (n) begin
      if ($urandom_range(1)) begin
        if ($urandom_range(19) == 0) add_literal($urandom_range(1, 128));
        else add_literal($urandom_range(1, 6));
      end else begin
        add_run($urandom_range(3, 130));
      end
    end
  endfunction

  task automatic short_file();
    int kind;
    int cut;
    if ($urandom_range(3) == 0) set_mode(1'($urandom_range(1)));
    kind = $urandom_range(9);
    if (kind < 6) begin
      add_header(1'b1);
      add_tokens($urandom_range(0, 4));
      cut = ($urandom_range(4) == 0) ? $urandom_range(1, file_q.size())
                                     : $urandom_range(8, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (kind < 8) begin
      add_header(1'b0);
      add_noise($urandom_range(0, 5));
    end else begin
      add_noise($urandom_range(1, 6));
    end
    send_file(1'b1);
  endtask

  initial begin : stim
    int start;
    int gap;
    int n;
    int ending;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    snd_idle = 37;
    rcv_idle = 62;

    for (int r = 0; r < DirRows; r++) begin
      if (DirTbl[r].kind == ROW_MODE) set_mode(DirTbl[r].b[0]);
      else feed_byte(DirTbl[r].b, DirTbl[r].lst, DirTbl[r].typed, DirTbl[r].st);
    end
    start = items_sent;
    while (items_sent - start < PhaseItems) short_file();

    snd_idle = 62;
    rcv_idle = 37;
    start = items_sent;
    while (items_sent - start < PhaseItems) short_file();

    snd_idle = 0;
    rcv_idle = 0;
    // one long page file with one of four endings
    ending = $urandom_range(3);
    case (ending)
      0: begin
        // 8K page ending on the filling byte
        set_mode(1'b1);
        add_header(1'b1);
        add_fill(HalfPageBytes);
        send_file(1'b1);
      end
      1: begin
        // 8K page filled, then trailing bytes
        set_mode(1'b1);
        add_header(1'b1);
        add_fill(HalfPageBytes);
        add_noise(2);
        send_file(1'b1);
      end
      2: begin
        // 8K page that overflows on its last token
        set_mode(1'b1);
        gap = $urandom_range(1, 100);
        add_header(1'b1);
        add_fill(HalfPageBytes - gap);
        n = $urandom_range((gap + 1 < 3) ? 3 : gap + 1, 130);
        file_q.insert(file_q.size(), 8'h80 | 8'(n - 3));
        add_noise($urandom_range(0, 3));
        send_file(1'b1);
      end
      default: begin
        // page shrinks under a partly written 16K page
        set_mode(1'b0);
        add_header(1'b1);
        add_fill(HalfPageBytes + $urandom_range(3, 400));
        send_file(1'b0);
        set_mode(1'b1);
        add_noise($urandom_range(1, 4));
        send_file(1'b1);
      end
    endcase

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0 && want_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> rle_page_stream_decoder.f
rtl/rpsd_pkg.sv
rtl/rpsd_ctrl.sv
rtl/rpsd_datapath.sv
rtl/rle_page_stream_decoder.sv
rtl/rpsd_checker.sv
dv/tb_rle_page_stream_decoder.sv
